/* rtl/bwpt_pkg.sv */
`timescale 1ns / 1ps
// bwpt_pkg: shared types and codes for the block write protection table
// used by the front, back and top level files; no dependencies

package bwpt_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OpW      = 3;
  localparam int unsigned MaskW    = 32;
  localparam int unsigned CountW   = 6;

  typedef enum logic [OpW-1:0] {
    OP_CHECK      = 3'd0,
    OP_ENABLE     = 3'd1,
    OP_DISABLE    = 3'd2,
    OP_GLOBAL_ON  = 3'd3,
    OP_GLOBAL_OFF = 3'd4,
    OP_GLOBAL_QRY = 3'd5,
    OP_REC_WRITE  = 3'd6,
    OP_ONCE_QRY   = 3'd7
  } bwpt_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW     = 3'd0,
    CFG_BLOCK_CNT  = 3'd1,
    CFG_CONFIGURED = 3'd2,
    CFG_STATIC     = 3'd3,
    CFG_WRITE_ONCE = 3'd4,
    CFG_AUTO_PROT  = 3'd5
  } bwpt_cfg_idx_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bwpt_bk_state_e;

  // classification of one word, worked out at the front
  typedef struct packed {
    logic valid;
    logic cfg;
    logic stat;
    logic once;
  } bwpt_class_t;

  localparam int unsigned ClassW = $bits(bwpt_class_t);

  // settings the back needs while executing
  typedef struct packed {
    logic [CfgDataW-1:0] window_ms;
    logic                auto_protect;
  } bwpt_back_cfg_t;

endpackage

/* rtl/block_write_protection_table_unit.sv */
`timescale 1ns / 1ps
// block write protection table: one result word for every operation word
// an input word passes the queue, the back's head latch and the result register
// the back takes no new word before it is through with the last: its sequencer reads
// the timestamp memory on the pop and executes the update in execute, where a stalled result holds it
// reset: all protection flags, timestamp valid bits and the global flag clear at once
// depends on bwpt_pkg, bwpt_front, bwpt_queue, bwpt_back

module block_write_protection_table_unit #(
  parameter int unsigned NUM_BLOCKS = 32,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] block_id_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        answer_o,
  output logic        id_valid_o
);
  import bwpt_pkg::*;

  localparam int unsigned IdxW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned QW   = OpW + ClassW + IdxW + TIME_BITS;

  bwpt_back_cfg_t       back_cfg;
  bwpt_op_e             f_op, b_op;
  bwpt_class_t          f_cls, b_cls;
  logic [IdxW-1:0]      f_idx, b_idx;
  logic [TIME_BITS-1:0] f_now, b_now;
  logic [QW-1:0]        q_wdata, q_rdata;
  logic                 q_full, q_empty, q_pop, q_push;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full;
  assign q_push      = in_valid_i && !q_full;

  bwpt_front #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .TIME_BITS  (TIME_BITS),
    .IDX_W      (IdxW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .operation_i (operation_i),
    .block_id_i  (block_id_i),
    .now_ms_i    (now_ms_i),
    .back_cfg_o  (back_cfg),
    .op_o        (f_op),
    .cls_o       (f_cls),
    .idx_o       (f_idx),
    .now_o       (f_now)
  );

  assign q_wdata = {f_op, f_cls, f_idx, f_now};

  bwpt_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  assign b_op  = bwpt_op_e'(q_rdata[QW-1 -: OpW]);
  assign b_cls = bwpt_class_t'(q_rdata[QW-OpW-1 -: ClassW]);
  assign b_idx = q_rdata[TIME_BITS+IdxW-1 -: IdxW];
  assign b_now = q_rdata[TIME_BITS-1:0];

  bwpt_back #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .TIME_BITS  (TIME_BITS),
    .IDX_W      (IdxW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (back_cfg),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .op_i        (b_op),
    .cls_i       (b_cls),
    .idx_i       (b_idx),
    .now_i       (b_now),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .answer_o    (answer_o),
    .id_valid_o  (id_valid_o)
  );

endmodule

/* rtl/bwpt_front.sv */
`timescale 1ns / 1ps
// bwpt_front: configuration registers and classification of incoming words
// depends on bwpt_pkg

module bwpt_front #(
  parameter int unsigned NUM_BLOCKS = 32,
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned IDX_W      = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [2:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i,
  input  logic [2:0]               operation_i,
  input  logic [15:0]              block_id_i,
  input  logic [31:0]              now_ms_i,
  output bwpt_pkg::bwpt_back_cfg_t back_cfg_o,
  output bwpt_pkg::bwpt_op_e       op_o,
  output bwpt_pkg::bwpt_class_t    cls_o,
  output logic [IDX_W-1:0]         idx_o,
  output logic [TIME_BITS-1:0]     now_o
);
  import bwpt_pkg::*;

  logic [CfgDataW-1:0] window_q;
  logic [CountW-1:0]   block_cnt_q;
  logic [MaskW-1:0]    configured_q;
  logic [MaskW-1:0]    static_q;
  logic [MaskW-1:0]    once_q;
  logic                auto_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= '0;
      block_cnt_q  <= '0;
      configured_q <= '0;
      static_q     <= '0;
      once_q       <= '0;
      auto_q       <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (bwpt_cfg_idx_e'(cfg_index_i))
        CFG_WINDOW:     window_q     <= cfg_data_i;
        CFG_BLOCK_CNT:  block_cnt_q  <= cfg_data_i[CountW-1:0];
        CFG_CONFIGURED: configured_q <= cfg_data_i;
        CFG_STATIC:     static_q     <= cfg_data_i;
        CFG_WRITE_ONCE: once_q       <= cfg_data_i;
        CFG_AUTO_PROT:  auto_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic id_valid;
  logic in_mask;
  logic cfg_bit;

  always_comb begin
    id_valid = (block_id_i < 16'(block_cnt_q)) && (block_id_i < 16'(NUM_BLOCKS));
    // ids past the mask width have no descriptor
    in_mask  = (block_id_i[15:5] == '0);
    cfg_bit  = id_valid && in_mask && configured_q[block_id_i[4:0]];
    cls_o.valid = id_valid;
    cls_o.cfg   = cfg_bit;
    cls_o.stat  = cfg_bit && static_q[block_id_i[4:0]];
    cls_o.once  = cfg_bit && once_q[block_id_i[4:0]];
  end

  assign op_o  = bwpt_op_e'(operation_i);
  assign idx_o = block_id_i[IDX_W-1:0];
  assign now_o = TIME_BITS'(now_ms_i);

  assign back_cfg_o.window_ms    = window_q;
  assign back_cfg_o.auto_protect = auto_q;

endmodule

/* rtl/bwpt_queue.sv */
`timescale 1ns / 1ps
// bwpt_queue: two-entry queue between front and back
// depends on bwpt_pkg only through the top level that sizes it

module bwpt_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      priority if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= wdata_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = slot_q[rd_ptr_q];

endmodule

/* rtl/bwpt_back.sv */
`timescale 1ns / 1ps
// bwpt_back: protection flags, timestamp memory, global flag and result register
// depends on bwpt_pkg

module bwpt_back #(
  parameter int unsigned NUM_BLOCKS = 32,
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned IDX_W      = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bwpt_pkg::bwpt_back_cfg_t cfg_i,
  input  logic                     q_empty_i,
  output logic                     q_pop_o,
  input  bwpt_pkg::bwpt_op_e       op_i,
  input  bwpt_pkg::bwpt_class_t    cls_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic [TIME_BITS-1:0]     now_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     answer_o,
  output logic                     id_valid_o
);
  import bwpt_pkg::*;

  localparam int unsigned CmpW = (TIME_BITS > CfgDataW) ? TIME_BITS : CfgDataW;

  bwpt_bk_state_e       st_q, st_d;
  bwpt_op_e             op_q;
  bwpt_class_t          cls_q;
  logic [IDX_W-1:0]     idx_q;
  logic [TIME_BITS-1:0] now_q;

  logic [NUM_BLOCKS-1:0] bp_q, bp_d;
  logic [NUM_BLOCKS-1:0] lwt_vld_q, lwt_vld_d;
  logic [TIME_BITS-1:0]  lwt_mem [NUM_BLOCKS];
  logic [TIME_BITS-1:0]  mem_rd_q;
  logic                  gp_q, gp_d;
  logic [TIME_BITS-1:0]  gst_q, gst_d;

  logic                 out_valid_q, answer_q, id_valid_q;
  logic                 exec;
  logic                 ans_d;
  logic                 mem_we;
  logic                 bp_rd;
  logic [TIME_BITS-1:0] last;
  logic [TIME_BITS-1:0] el_blk, el_glb;
  logic                 open_blk, open_glb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BK_IDLE;
    else         st_q <= st_d;
  end

  always_comb begin
    st_d    = st_q;
    q_pop_o = 1'b0;
    exec    = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          st_d    = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          exec = 1'b1;
          st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  // head word is latched while its timestamp is read
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      op_q     <= op_i;
      cls_q    <= cls_i;
      idx_q    <= idx_i;
      now_q    <= now_i;
      mem_rd_q <= lwt_mem[idx_i];
    end
    if (mem_we) lwt_mem[idx_q] <= now_q;
  end

  always_comb begin
    bp_rd    = cls_q.valid && bp_q[idx_q];
    last     = (cls_q.valid && lwt_vld_q[idx_q]) ? mem_rd_q : '0;
    el_blk   = now_q - last;
    el_glb   = now_q - gst_q;
    open_blk = CmpW'(el_blk) < CmpW'(cfg_i.window_ms);
    open_glb = CmpW'(el_glb) < CmpW'(cfg_i.window_ms);
  end

  always_comb begin
    bp_d      = bp_q;
    lwt_vld_d = lwt_vld_q;
    gp_d      = gp_q;
    gst_d     = gst_q;
    ans_d     = 1'b0;
    mem_we    = 1'b0;
    if (exec) begin
      unique case (op_q)
        OP_CHECK: begin
          priority if (!cls_q.valid || !cls_q.cfg || gp_q || cls_q.stat) begin
            ans_d = 1'b1;
          end else if (bp_rd && open_blk) begin
            ans_d = 1'b1;
          end else begin
            // lapsed flag is dropped on check
            bp_d[idx_q] = 1'b0;
            ans_d = cls_q.once && (last != '0);
          end
        end
        OP_ENABLE: begin
          if (cls_q.valid) begin
            bp_d[idx_q]      = 1'b1;
            lwt_vld_d[idx_q] = 1'b1;
            mem_we           = 1'b1;
          end
        end
        OP_DISABLE: begin
          if (cls_q.valid && !cls_q.once) bp_d[idx_q] = 1'b0;
        end
        OP_GLOBAL_ON: begin
          gp_d  = 1'b1;
          gst_d = now_q;
        end
        OP_GLOBAL_OFF: gp_d = 1'b0;
        OP_GLOBAL_QRY: begin
          if (gp_q) begin
            if (open_glb) ans_d = 1'b1;
            else          gp_d  = 1'b0;
          end
        end
        OP_REC_WRITE: begin
          if (cls_q.valid && cls_q.cfg) begin
            lwt_vld_d[idx_q] = 1'b1;
            mem_we           = 1'b1;
            if ((cfg_i.auto_protect && cls_q.stat) || cls_q.once) bp_d[idx_q] = 1'b1;
          end
        end
        OP_ONCE_QRY: ans_d = cls_q.once;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q        <= '0;
      lwt_vld_q   <= '0;
      gp_q        <= 1'b0;
      gst_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bp_q      <= bp_d;
      lwt_vld_q <= lwt_vld_d;
      gp_q      <= gp_d;
      gst_q     <= gst_d;
      if (exec)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      answer_q   <= ans_d;
      id_valid_q <= cls_q.valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;
  assign id_valid_o  = id_valid_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BK_EXEC && out_valid_q && !out_ready_i) |=> (st_q == BK_EXEC))
    else $error("back left execute while result was stalled");

  a_no_answer_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && op_q != OP_CHECK && op_q != OP_GLOBAL_QRY && op_q != OP_ONCE_QRY)
    |=> !answer_q)
    else $error("answer set for an update operation");

  a_glb_answer_keeps_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && op_q == OP_GLOBAL_QRY && ans_d) |=> gp_q)
    else $error("global flag dropped on an active query");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (st_q == BK_EXEC))
    else $error("pop did not start execution");

endmodule
